>>> rtl/dsq_pkg.sv
// Package for the decimal square root block: channel types, unit control and helpers.
`default_nettype none
package dsq_pkg;

   localparam logic [6:0] PAIR_MAX  = 7'd99;
   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam logic [6:0] RADIX     = 7'd10;

   typedef struct packed {
      logic [6:0] digit_pair;
      logic       first_pair;
      logic       last_pair;
   } dsq_req_type;

   typedef struct packed {
      logic [3:0] root_digit;
      logic       last_digit;
      logic       overflow;
   } dsq_rsp_type;

   typedef struct packed {
      logic       clear;
      logic       enable;
      logic       pos_zero;
      logic       pos_one;
      logic [3:0] trial_digit;
   } dsq_unit_ctrl_type;

   // Quotient by ten through a reciprocal multiply; exact for every 7-bit input, 0 to 127.
   function automatic logic [3:0] div10(input logic [6:0] value);
      logic [14:0] product;
      product = 15'(value) * 15'd205;
      return product[14:11];
   endfunction

endpackage
`default_nettype wire

>>> rtl/decimal_digit_by_digit_sqrt.sv
// Top level of the decimal digit-by-digit square root: sequencer, stores and digit unit.
// A request with k pairs already taken runs up to ten passes over positions 0 to k+2
// (trial digits 1..9 until one overshoots, then one write-back pass) before the result
// is handed off; overflow requests skip the passes. Requests are not taken while busy;
// the shared digit unit walks one BCD digit a cycle.
// Reset is synchronous and clears control state only; the digit stores are never swept,
// since the pair count marks which digits hold live data.
`default_nettype none
module decimal_digit_by_digit_sqrt #(
   parameter int MAX_ROOT_DIGITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire dsq_pkg::dsq_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output dsq_pkg::dsq_rsp_type      rsp_data
);
   import dsq_pkg::*;

   // Count of pairs taken, position within a pass, and store addresses.
   localparam int CW      = $clog2(MAX_ROOT_DIGITS + 1);
   localparam int AW      = $clog2(MAX_ROOT_DIGITS + 3);
   localparam int ROOT_AW = (MAX_ROOT_DIGITS > 1) ? $clog2(MAX_ROOT_DIGITS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] base_ff, base_in;
   logic [3:0]    ones_ff, ones_in;
   logic [3:0]    tens_ff, tens_in;
   logic          last_ff, last_in;
   logic          ovf_ff, ovf_in;
   logic [3:0]    trial_ff, trial_in;
   logic [3:0]    best_ff, best_in;
   logic          final_ff, final_in;
   logic [AW-1:0] issue_ff, issue_in;
   logic          issuing_ff, issuing_in;
   logic          proc_ff, proc_in;
   logic [AW-1:0] proc_pos_ff, proc_pos_in;
   logic [AW-1:0] proc_addr_ff, proc_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   dsq_rsp_type   rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [CW-1:0]     count_start;
   logic [6:0]        pair_sat;
   logic [3:0]        pair_tens;
   logic [AW-1:0]     count_wide;
   logic [AW-1:0]     last_pos;
   logic              pass_end;
   logic              rsp_free;
   logic [ROOT_AW-1:0] root_rd_addr;
   logic              root_rd_valid;
   logic [AW-1:0]     rem_rd_addr;
   logic              rem_rd_valid;
   logic              root_wr_en;
   logic              rem_wr_en;
   logic [3:0]        root_rd_digit;
   logic [3:0]        rem_rd_digit;
   logic [3:0]        diff_digit;
   logic              borrow_out;
   dsq_unit_ctrl_type unit_ctrl;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Pairs above 99 are treated as 99; the pair splits into its two BCD digits here.
   assign pair_sat    = (req_data.digit_pair > PAIR_MAX) ? PAIR_MAX : req_data.digit_pair;
   assign pair_tens   = div10(pair_sat);
   assign count_start = req_data.first_pair ? '0 : count_ff;

   // A pass walks positions 0 to k+2 of the working value, least significant first.
   assign count_wide = AW'(count_ff);
   assign last_pos   = count_wide + AW'(2);
   assign pass_end   = proc_ff && (proc_pos_ff == last_pos);

   // Root digits sit in arrival order, so root digit j (least significant first) lives at
   // address k-1-j; position p of the pass needs root digit p-1.
   assign root_rd_valid = (issue_ff != '0) && (issue_ff <= count_wide);
   assign root_rd_addr  = ROOT_AW'(count_wide - issue_ff);

   // The remainder is kept at a moving base: each pair shifts it up two decimal places,
   // so the base steps down by two and new digits overwrite the ones just read in place.
   // After a clear nothing is live until the first pair has been written back.
   assign rem_rd_valid = (issue_ff >= AW'(2)) && (count_ff != '0);
   assign rem_rd_addr  = base_ff + issue_ff - AW'(2);

   assign rem_wr_en  = proc_ff && final_ff;
   assign root_wr_en = pass_end && final_ff;

   always_comb begin
      unit_ctrl.clear       = accept || pass_end;
      unit_ctrl.enable      = proc_ff;
      unit_ctrl.pos_zero    = (proc_pos_ff == '0);
      unit_ctrl.pos_one     = (proc_pos_ff == AW'(1));
      unit_ctrl.trial_digit = final_ff ? best_ff : trial_ff;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      ones_in      = ones_ff;
      tens_in      = tens_ff;
      last_in      = last_ff;
      ovf_in       = ovf_ff;
      trial_in     = trial_ff;
      best_in      = best_ff;
      final_in     = final_ff;
      issue_in     = issue_ff;
      issuing_in   = issuing_ff;
      proc_in      = 1'b0;
      proc_pos_in  = issue_ff;
      proc_addr_in = rem_rd_addr;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = count_start;
               ones_in  = 4'(pair_sat - 7'(pair_tens) * RADIX);
               tens_in  = pair_tens;
               last_in  = req_data.last_pair;
               best_in  = 4'd0;
               if (count_start >= CW'(MAX_ROOT_DIGITS)) begin
                  // Capacity is full: the state is left alone and the digit reads zero.
                  ovf_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  ovf_in     = 1'b0;
                  trial_in   = 4'd1;
                  final_in   = 1'b0;
                  issue_in   = '0;
                  issuing_in = 1'b1;
                  state_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            proc_in = issuing_ff;
            if (issuing_ff) begin
               if (issue_ff == last_pos) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_in = issue_ff + AW'(1);
               end
            end
            if (pass_end) begin
               if (final_ff) begin
                  count_in = count_ff + CW'(1);
                  base_in  = base_ff - AW'(2);
                  state_in = ST_FINISH;
               end else begin
                  // A final borrow means this trial product exceeds the working value.
                  if (borrow_out || (trial_ff == DIGIT_MAX)) begin
                     final_in = 1'b1;
                  end
                  if (!borrow_out) begin
                     best_in  = trial_ff;
                     trial_in = trial_ff + 4'd1;
                  end
                  issue_in   = '0;
                  issuing_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.root_digit = best_ff;
               rsp_data_in.last_digit = last_ff;
               rsp_data_in.overflow   = ovf_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         issuing_ff   <= 1'b0;
         proc_ff      <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         issuing_ff   <= issuing_in;
         proc_ff      <= proc_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ones_ff      <= ones_in;
      tens_ff      <= tens_in;
      last_ff      <= last_in;
      ovf_ff       <= ovf_in;
      trial_ff     <= trial_in;
      best_ff      <= best_in;
      issue_ff     <= issue_in;
      proc_pos_ff  <= proc_pos_in;
      proc_addr_ff <= proc_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   dsq_stores #(
      .ROOT_DEPTH (MAX_ROOT_DIGITS),
      .REM_AW     (AW)
   ) u_stores (
      .clock         (clock),
      .root_rd_addr  (root_rd_addr),
      .root_rd_valid (root_rd_valid),
      .root_wr_en    (root_wr_en),
      .root_wr_addr  (ROOT_AW'(count_ff)),
      .root_wr_digit (best_ff),
      .rem_rd_addr   (rem_rd_addr),
      .rem_rd_valid  (rem_rd_valid),
      .rem_wr_en     (rem_wr_en),
      .rem_wr_addr   (proc_addr_ff),
      .rem_wr_digit  (diff_digit),
      .root_rd_digit (root_rd_digit),
      .rem_rd_digit  (rem_rd_digit)
   );

   dsq_digit_unit u_digit_unit (
      .clock      (clock),
      .ctrl       (unit_ctrl),
      .pair_ones  (ones_ff),
      .pair_tens  (tens_ff),
      .root_digit (root_rd_digit),
      .rem_digit  (rem_rd_digit),
      .diff_digit (diff_digit),
      .borrow_out (borrow_out)
   );

endmodule
`default_nettype wire

>>> rtl/dsq_digit_unit.sv
// Shared digit unit: one BCD digit of (20*root+d)*d subtracted from the working value.
`default_nettype none
module dsq_digit_unit (
   input  wire logic                        clock,
   input  wire dsq_pkg::dsq_unit_ctrl_type  ctrl,
   input  wire logic [3:0]                  pair_ones,
   input  wire logic [3:0]                  pair_tens,
   input  wire logic [3:0]                  root_digit,
   input  wire logic [3:0]                  rem_digit,
   output logic [3:0]                       diff_digit,
   output logic                             borrow_out
);
   import dsq_pkg::*;

   logic       double_carry_ff, double_carry_in;
   logic [3:0] mult_carry_ff, mult_carry_in;
   logic       borrow_ff, borrow_in;

   logic [4:0] doubled;
   logic [3:0] factor_digit;
   logic [7:0] product;
   logic [6:0] product_sum;
   logic [3:0] trial_digit;
   logic [3:0] cur_digit;
   logic [4:0] diff_raw;

   always_comb begin
      doubled = {root_digit, 1'b0} + 5'(double_carry_ff);
      if (ctrl.pos_zero) begin
         factor_digit    = ctrl.trial_digit;
         double_carry_in = 1'b0;
      end else if (doubled >= 5'(RADIX)) begin
         factor_digit    = 4'(doubled - 5'(RADIX));
         double_carry_in = 1'b1;
      end else begin
         factor_digit    = doubled[3:0];
         double_carry_in = 1'b0;
      end

      product       = 8'(factor_digit) * 8'(ctrl.trial_digit);
      product_sum   = product[6:0] + 7'(mult_carry_ff);
      mult_carry_in = div10(product_sum);
      trial_digit   = 4'(product_sum - 7'(mult_carry_in) * RADIX);

      if (ctrl.pos_zero) begin
         cur_digit = pair_ones;
      end else if (ctrl.pos_one) begin
         cur_digit = pair_tens;
      end else begin
         cur_digit = rem_digit;
      end

      diff_raw   = {1'b0, cur_digit} - {1'b0, trial_digit} - 5'(borrow_ff);
      borrow_in  = diff_raw[4];
      diff_digit = borrow_in ? 4'(diff_raw + 5'(RADIX)) : diff_raw[3:0];
      borrow_out = borrow_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         double_carry_ff <= 1'b0;
         mult_carry_ff   <= 4'd0;
         borrow_ff       <= 1'b0;
      end else if (ctrl.enable) begin
         double_carry_ff <= double_carry_in;
         mult_carry_ff   <= mult_carry_in;
         borrow_ff       <= borrow_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/dsq_stores.sv
// Root and remainder digit memories with registered, masked reads.
`default_nettype none
module dsq_stores #(
   parameter  int ROOT_DEPTH = 32,
   parameter  int REM_AW     = 6,
   localparam int ROOT_AW    = (ROOT_DEPTH > 1) ? $clog2(ROOT_DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic [ROOT_AW-1:0] root_rd_addr,
   input  wire logic               root_rd_valid,
   input  wire logic               root_wr_en,
   input  wire logic [ROOT_AW-1:0] root_wr_addr,
   input  wire logic [3:0]         root_wr_digit,
   input  wire logic [REM_AW-1:0]  rem_rd_addr,
   input  wire logic               rem_rd_valid,
   input  wire logic               rem_wr_en,
   input  wire logic [REM_AW-1:0]  rem_wr_addr,
   input  wire logic [3:0]         rem_wr_digit,
   output logic [3:0]              root_rd_digit,
   output logic [3:0]              rem_rd_digit
);
   localparam int REM_DEPTH = 2 ** REM_AW;

   logic [3:0] root_mem [0:ROOT_DEPTH-1];
   logic [3:0] rem_mem  [0:REM_DEPTH-1];
   logic [3:0] root_rd_ff;
   logic [3:0] rem_rd_ff;
   logic       root_valid_ff;
   logic       rem_valid_ff;

   always_ff @(posedge clock) begin
      if (root_wr_en) begin
         root_mem[root_wr_addr] <= root_wr_digit;
      end
      root_rd_ff    <= root_mem[root_rd_addr];
      root_valid_ff <= root_rd_valid;
   end

   always_ff @(posedge clock) begin
      if (rem_wr_en) begin
         rem_mem[rem_wr_addr] <= rem_wr_digit;
      end
      rem_rd_ff    <= rem_mem[rem_rd_addr];
      rem_valid_ff <= rem_rd_valid;
   end

   // Digits outside the filled region read as zero.
   assign root_rd_digit = root_valid_ff ? root_rd_ff : 4'd0;
   assign rem_rd_digit  = rem_valid_ff  ? rem_rd_ff  : 4'd0;

endmodule
`default_nettype wire
